>>> rtl/amd_pkg.sv
package amd_pkg;

  localparam int PIXELS              = 4;
  localparam int COLORS              = 3;
  localparam int BYTE_W              = 8;
  localparam int ALPHA_BYTE          = 3;
  localparam int SUM_W               = 10;
  localparam int WEIGHT_W            = 13;
  localparam int PROD_W              = 21;
  localparam int ACC_W               = 23;
  localparam int WEIGHT_SHIFT        = 12;
  localparam int AVG_SHIFT           = 2;
  localparam int DIV_STEPS           = 13;
  localparam int DIV_STEPS_PER_STAGE = 4;

  localparam logic [SUM_W-1:0]    ALPHA_SUM_FULL = SUM_W'(1020);
  localparam logic [WEIGHT_W-1:0] WEIGHT_EVEN    = WEIGHT_W'(1024);
  localparam logic [BYTE_W-1:0]   CHANNEL_MAX    = BYTE_W'(255);

  typedef logic [BYTE_W-1:0]                   byte_t;
  typedef logic [31:0]                         pixel_t;
  typedef logic [SUM_W-1:0]                    sum_t;
  typedef logic [WEIGHT_W-1:0]                 weight_t;
  typedef logic [COLORS-1:0][BYTE_W-1:0]       colors_t;
  typedef logic [COLORS-1:0][PROD_W-1:0]       prods_t;

endpackage

>>> rtl/amd_in_if.sv
interface amd_in_if;
  logic            valid;
  logic            ready;
  amd_pkg::pixel_t top_left_pixel;
  amd_pkg::pixel_t top_right_pixel;
  amd_pkg::pixel_t bottom_left_pixel;
  amd_pkg::pixel_t bottom_right_pixel;

  modport source (
    output valid, top_left_pixel, top_right_pixel, bottom_left_pixel, bottom_right_pixel,
    input  ready
  );
  modport sink (
    input  valid, top_left_pixel, top_right_pixel, bottom_left_pixel, bottom_right_pixel,
    output ready
  );
endinterface

>>> rtl/amd_out_if.sv
interface amd_out_if;
  logic           valid;
  logic           ready;
  amd_pkg::byte_t channel_zero;
  amd_pkg::byte_t channel_one;
  amd_pkg::byte_t channel_two;
  amd_pkg::byte_t alpha_out;

  modport source (
    output valid, channel_zero, channel_one, channel_two, alpha_out,
    input  ready
  );
  modport sink (
    input  valid, channel_zero, channel_one, channel_two, alpha_out,
    output ready
  );
endinterface

>>> rtl/amd_lane.sv
module amd_lane #(
  parameter int STEPS_PER_STAGE = amd_pkg::DIV_STEPS_PER_STAGE,
  localparam int STAGES = (amd_pkg::DIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE
) (
  input  logic             clk,
  input  logic [STAGES:0]  load,
  input  amd_pkg::byte_t   alpha,
  input  amd_pkg::sum_t    k,
  input  logic             even,
  input  amd_pkg::colors_t colors,
  output amd_pkg::prods_t  prods
);

  amd_pkg::sum_t    st_r    [STAGES+1];
  amd_pkg::weight_t st_q    [STAGES+1];
  amd_pkg::sum_t    st_k    [STAGES+1];
  logic             st_even [STAGES+1];
  amd_pkg::colors_t st_col  [STAGES+1];

  assign st_r[0]    = amd_pkg::SUM_W'(alpha);
  assign st_q[0]    = '0;
  assign st_k[0]    = k;
  assign st_even[0] = even;
  assign st_col[0]  = colors;

  // Restoring division of alpha * 4096 by the alpha sum, up to STEPS_PER_STAGE quotient bits per stage.
  for (genvar d = 0; d < STAGES; d++) begin : g_div
    amd_pkg::sum_t    r_next;
    amd_pkg::weight_t q_next;

    always_comb begin
      logic [amd_pkg::SUM_W:0] t;
      amd_pkg::sum_t           r;
      amd_pkg::weight_t        q;
      r = st_r[d];
      q = st_q[d];
      t = '0;
      for (int s = 0; s < STEPS_PER_STAGE; s++) begin
        if (d * STEPS_PER_STAGE + s < amd_pkg::DIV_STEPS) begin
          if (d * STEPS_PER_STAGE + s == 0) begin
            t = {1'b0, r};
          end else begin
            t = {r, 1'b0};
          end
          if (t >= {1'b0, st_k[d]}) begin
            t = t - {1'b0, st_k[d]};
            q = {q[amd_pkg::WEIGHT_W-2:0], 1'b1};
          end else begin
            q = {q[amd_pkg::WEIGHT_W-2:0], 1'b0};
          end
          r = t[amd_pkg::SUM_W-1:0];
        end
      end
      r_next = r;
      q_next = q;
    end

    always_ff @(posedge clk) begin
      if (load[d]) begin
        st_r[d+1]    <= r_next;
        st_q[d+1]    <= q_next;
        st_k[d+1]    <= st_k[d];
        st_even[d+1] <= st_even[d];
        st_col[d+1]  <= st_col[d];
      end
    end
  end

  amd_pkg::weight_t weight;

  assign weight = st_even[STAGES] ? amd_pkg::WEIGHT_EVEN : st_q[STAGES];

  always_ff @(posedge clk) begin
    if (load[STAGES]) begin
      for (int c = 0; c < amd_pkg::COLORS; c++) begin
        prods[c] <= amd_pkg::PROD_W'(st_col[STAGES][c]) * amd_pkg::PROD_W'(weight);
      end
    end
  end

endmodule

>>> rtl/amd_merge.sv
module amd_merge (
  input  logic             clk,
  input  logic             load,
  input  amd_pkg::prods_t  prods [amd_pkg::PIXELS],
  input  amd_pkg::byte_t   avg,
  output amd_pkg::colors_t channels,
  output amd_pkg::byte_t   alpha_avg
);

  amd_pkg::colors_t channels_next;

  always_comb begin
    logic [amd_pkg::ACC_W-1:0]                    acc;
    logic [amd_pkg::ACC_W-amd_pkg::WEIGHT_SHIFT-1:0] scaled;
    for (int c = 0; c < amd_pkg::COLORS; c++) begin
      acc = '0;
      for (int p = 0; p < amd_pkg::PIXELS; p++) begin
        acc = acc + amd_pkg::ACC_W'(prods[p][c]);
      end
      scaled = acc[amd_pkg::ACC_W-1:amd_pkg::WEIGHT_SHIFT];
      if (scaled > (amd_pkg::ACC_W-amd_pkg::WEIGHT_SHIFT)'(amd_pkg::CHANNEL_MAX)) begin
        channels_next[c] = amd_pkg::CHANNEL_MAX;
      end else begin
        channels_next[c] = scaled[amd_pkg::BYTE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      channels  <= channels_next;
      alpha_avg <= avg;
    end
  end

endmodule

>>> rtl/alpha_weighted_mip_downsample.sv
// Alpha-weighted 2x2 mip downsample: each input beat carries four RGBA8 pixels and yields
// one output beat with three alpha-weighted color channels and the averaged alpha. One beat
// is accepted every cycle unless the pipeline is stalled, and results leave in order. The
// per-pixel weight divide is a pipelined restoring divider in each of the four pixel lanes
// that resolves DIV_STEPS_PER_STAGE bits of the 13-bit weight per stage (default four, valid
// range 1 to 13). Every stage holds its own valid bit and empty stages close up, so new
// beats keep entering while a finished result waits for the sink, and the pipeline stalls
// only once every stage is full.
module alpha_weighted_mip_downsample #(
  parameter int DIV_STEPS_PER_STAGE = amd_pkg::DIV_STEPS_PER_STAGE
) (
  input logic       clk,
  input logic       rst,
  amd_in_if.sink    pix_in,
  amd_out_if.source pix_out
);

  localparam int DIV_STAGES = (amd_pkg::DIV_STEPS + DIV_STEPS_PER_STAGE - 1) /
                              DIV_STEPS_PER_STAGE;
  localparam int NUM_STAGES = DIV_STAGES + 3;

  logic [NUM_STAGES-1:0] v;
  logic [NUM_STAGES-1:0] load;

  always_comb begin
    load[NUM_STAGES-1] = !v[NUM_STAGES-1] || pix_out.ready;
    for (int s = NUM_STAGES - 2; s >= 0; s--) begin
      load[s] = !v[s] || load[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (load[0]) begin
        v[0] <= pix_in.valid;
      end
      for (int s = 1; s < NUM_STAGES; s++) begin
        if (load[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  assign pix_in.ready  = load[0];
  assign pix_out.valid = v[NUM_STAGES-1];

  amd_pkg::pixel_t px_in [amd_pkg::PIXELS];
  amd_pkg::sum_t   k_in;

  assign px_in[0] = pix_in.top_left_pixel;
  assign px_in[1] = pix_in.top_right_pixel;
  assign px_in[2] = pix_in.bottom_left_pixel;
  assign px_in[3] = pix_in.bottom_right_pixel;

  always_comb begin
    k_in = '0;
    for (int p = 0; p < amd_pkg::PIXELS; p++) begin
      k_in = k_in + amd_pkg::SUM_W'(px_in[p][amd_pkg::ALPHA_BYTE*amd_pkg::BYTE_W +:
                                             amd_pkg::BYTE_W]);
    end
  end

  amd_pkg::pixel_t px_q [amd_pkg::PIXELS];
  amd_pkg::sum_t   k_q;
  logic            even_q;
  amd_pkg::byte_t  avg_st [DIV_STAGES+2];

  always_ff @(posedge clk) begin
    if (load[0]) begin
      px_q      <= px_in;
      k_q       <= k_in;
      even_q    <= (k_in == '0) || (k_in == amd_pkg::ALPHA_SUM_FULL);
      avg_st[0] <= k_in[amd_pkg::SUM_W-1:amd_pkg::AVG_SHIFT];
    end
    for (int s = 1; s < DIV_STAGES + 2; s++) begin
      if (load[s]) begin
        avg_st[s] <= avg_st[s-1];
      end
    end
  end

  amd_pkg::prods_t lane_prods [amd_pkg::PIXELS];

  for (genvar p = 0; p < amd_pkg::PIXELS; p++) begin : g_lane
    amd_pkg::colors_t lane_colors;

    assign lane_colors = px_q[p][amd_pkg::COLORS*amd_pkg::BYTE_W-1:0];

    amd_lane #(
      .STEPS_PER_STAGE(DIV_STEPS_PER_STAGE)
    ) u_lane (
      .clk   (clk),
      .load  (load[DIV_STAGES+1:1]),
      .alpha (px_q[p][amd_pkg::ALPHA_BYTE*amd_pkg::BYTE_W +: amd_pkg::BYTE_W]),
      .k     (k_q),
      .even  (even_q),
      .colors(lane_colors),
      .prods (lane_prods[p])
    );
  end

  amd_pkg::colors_t channels;

  amd_merge u_merge (
    .clk      (clk),
    .load     (load[NUM_STAGES-1]),
    .prods    (lane_prods),
    .avg      (avg_st[DIV_STAGES+1]),
    .channels (channels),
    .alpha_avg(pix_out.alpha_out)
  );

  assign pix_out.channel_zero = channels[0];
  assign pix_out.channel_one  = channels[1];
  assign pix_out.channel_two  = channels[2];

  a_ready_when_first_empty : assert property (
    @(posedge clk) disable iff (rst) !v[0] |-> pix_in.ready
  ) else $error("Input stalled while the first stage was empty.");

  a_full_stall_blocks_input : assert property (
    @(posedge clk) disable iff (rst) (&v && !pix_out.ready) |-> !pix_in.ready
  ) else $error("Input taken while the whole pipeline was stalled.");

  a_held_result_stays : assert property (
    @(posedge clk) disable iff (rst) (pix_out.valid && !pix_out.ready) |=> pix_out.valid
  ) else $error("A waiting result was dropped.");

  a_reset_clears_output : assert property (
    @(posedge clk) $past(rst) |-> !pix_out.valid
  ) else $error("Output valid after reset.");

endmodule

>>> verif/alpha_weighted_mip_downsample_tb.sv
`timescale 1ns / 1ps

module alpha_weighted_mip_downsample_tb;
  import amd_pkg::*;

  localparam int unsigned WEIGHT_SCALE  = 4096;
  localparam int          RANDOM_BLOCKS = 1400;
  localparam int          CHUNK_BLOCKS  = 100;
  localparam int          DRAIN_CYCLES  = 16;
  localparam int          CYCLE_LIMIT   = 200000;

  typedef logic [PIXELS-1:0][31:0] block_t;

  typedef struct packed {
    byte_t alpha;
    byte_t ch2;
    byte_t ch1;
    byte_t ch0;
  } mip_pixel_t;

  typedef struct packed {
    block_t     blk;
    logic       typed;
    mip_pixel_t want;
  } stim_row_t;

  logic clk;
  logic rst;

  amd_in_if  pix_in_bus ();
  amd_out_if pix_out_bus ();

  alpha_weighted_mip_downsample u_dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in_bus),
    .pix_out (pix_out_bus)
  );

  mip_pixel_t pending_pixels[$];
  stim_row_t  directed_rows[$];
  int         mismatch_count = 0;
  int         cycle_count    = 0;
  bit         idle_on        = 1'b1;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic mip_pixel_t predict_downsample(input block_t blk);
    int unsigned alpha_sum;
    int unsigned weight [PIXELS];
    int unsigned acc;
    mip_pixel_t  res;
    alpha_sum = 0;
    for (int i = 0; i < PIXELS; i++) begin
      alpha_sum += blk[i][8*ALPHA_BYTE +: BYTE_W];
    end
    for (int i = 0; i < PIXELS; i++) begin
      if (alpha_sum == 0 || alpha_sum == ALPHA_SUM_FULL) begin
        weight[i] = WEIGHT_EVEN;
      end else begin
        weight[i] = (WEIGHT_SCALE * blk[i][8*ALPHA_BYTE +: BYTE_W]) / alpha_sum;
      end
    end
    for (int c = 0; c < COLORS; c++) begin
      acc = 0;
      for (int i = 0; i < PIXELS; i++) begin
        acc += blk[i][8*c +: BYTE_W] * weight[i];
      end
      acc = acc >> WEIGHT_SHIFT;
      if (acc > CHANNEL_MAX) begin
        acc = CHANNEL_MAX;
      end
      case (c)
        0: res.ch0 = acc[BYTE_W-1:0];
        1: res.ch1 = acc[BYTE_W-1:0];
        default: res.ch2 = acc[BYTE_W-1:0];
      endcase
    end
    res.alpha = byte_t'(alpha_sum >> AVG_SHIFT);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic table_row(input pixel_t tl, input pixel_t tr, input pixel_t bl,
                           input pixel_t br, input logic typed, input byte_t ch0,
                           input byte_t ch1, input byte_t ch2, input byte_t alpha);
    stim_row_t row;
    row.blk        = {br, bl, tr, tl};
    row.typed      = typed;
    row.want.ch0   = ch0;
    row.want.ch1   = ch1;
    row.want.ch2   = ch2;
    row.want.alpha = alpha;
    directed_rows.push_back(row);
  endtask

  task automatic send_block(input block_t blk, input mip_pixel_t want);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      pix_in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_in_bus.valid              <= 1'b1;
    pix_in_bus.top_left_pixel     <= blk[0];
    pix_in_bus.top_right_pixel    <= blk[1];
    pix_in_bus.bottom_left_pixel  <= blk[2];
    pix_in_bus.bottom_right_pixel <= blk[3];
    do @(posedge clk); while (!pix_in_bus.ready);
    pending_pixels.push_back(want);
  endtask

  task automatic wait_for_results();
    pix_in_bus.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  function automatic block_t random_block();
    block_t blk;
    int     mode;
    int     lone;
    mode = $urandom_range(0, 9);
    lone = $urandom_range(0, PIXELS - 1);
    for (int i = 0; i < PIXELS; i++) begin
      blk[i] = $urandom();
      case (mode)
        0: blk[i][31:24] = 8'h00;
        1: blk[i][31:24] = 8'hFF;
        2, 3: begin
          case ($urandom_range(0, 3))
            0: blk[i][31:24] = 8'h00;
            1: blk[i][31:24] = 8'h01;
            2: blk[i][31:24] = 8'hFE;
            default: blk[i][31:24] = 8'hFF;
          endcase
        end
        4: if (i != lone) blk[i][31:24] = 8'h00;
        default: ;
      endcase
    end
    return blk;
  endfunction

  initial begin
    rst                            <= 1'b1;
    pix_in_bus.valid               <= 1'b0;
    pix_in_bus.top_left_pixel      <= '0;
    pix_in_bus.top_right_pixel     <= '0;
    pix_in_bus.bottom_left_pixel   <= '0;
    pix_in_bus.bottom_right_pixel  <= '0;
    pix_out_bus.ready              <= 1'b0;

    // Rows marked typed carry a hand-checked result; the others use the predictor.
    table_row(32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 1'b1,
              8'h00, 8'h00, 8'h00, 8'h00);
    table_row(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
              8'hFF, 8'hFF, 8'hFF, 8'hFF);
    table_row(32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF, 1'b1,
              8'hFF, 8'hFF, 8'hFF, 8'h00);
    table_row(32'hFF000000, 32'hFF000000, 32'hFF000000, 32'hFF000000, 1'b1,
              8'h00, 8'h00, 8'h00, 8'hFF);
    table_row(32'hFF332211, 32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF, 1'b1,
              8'h11, 8'h22, 8'h33, 8'h3F);
    table_row(32'h00ABCDEF, 32'h00ABCDEF, 32'h00ABCDEF, 32'hFF665544, 1'b1,
              8'h44, 8'h55, 8'h66, 8'h3F);
    table_row(32'h01123456, 32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF, 1'b1,
              8'h56, 8'h34, 8'h12, 8'h00);
    table_row(32'hFFFFFFFF, 32'h00000000, 32'h00000000, 32'h00000000, 1'b1,
              8'hFF, 8'hFF, 8'hFF, 8'h3F);
    table_row(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFE000000, 1'b0,
              8'h00, 8'h00, 8'h00, 8'h00);
    table_row(32'h01102030, 32'h01405060, 32'h01708090, 32'h01A0B0C0, 1'b0,
              8'h00, 8'h00, 8'h00, 8'h00);
    table_row(32'h01FF00FF, 32'h0200FF00, 32'h03FFFF00, 32'h0400FFFF, 1'b0,
              8'h00, 8'h00, 8'h00, 8'h00);
    table_row(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555, 1'b0,
              8'h00, 8'h00, 8'h00, 8'h00);
    table_row(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 1'b0,
              8'h00, 8'h00, 8'h00, 8'h00);
    table_row(32'h80FFFFFF, 32'h40FFFFFF, 32'h20FFFFFF, 32'h10FFFFFF, 1'b0,
              8'h00, 8'h00, 8'h00, 8'h00);
    table_row(32'hFFFFFFFF, 32'hFF000000, 32'h00FFFFFF, 32'h00000000, 1'b0,
              8'h00, 8'h00, 8'h00, 8'h00);
    table_row(32'h7F123456, 32'h80654321, 32'h7FFEDCBA, 32'h80ABCDEF, 1'b0,
              8'h00, 8'h00, 8'h00, 8'h00);
    table_row(32'h12345678, 32'h9ABCDEF0, 32'h0FEDCBA9, 32'h87654321, 1'b0,
              8'h00, 8'h00, 8'h00, 8'h00);
    table_row(32'h01FFFFFF, 32'h01FFFFFF, 32'h01FFFFFF, 32'h00FFFFFF, 1'b0,
              8'h00, 8'h00, 8'h00, 8'h00);
    table_row(32'h00000000, 32'h00000000, 32'h80000000, 32'h00000000, 1'b0,
              8'h00, 8'h00, 8'h00, 8'h00);
    table_row(32'hFEFFFFFF, 32'hFF000000, 32'hFFFFFFFF, 32'hFF000000, 1'b0,
              8'h00, 8'h00, 8'h00, 8'h00);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      send_block(directed_rows[r].blk,
                 directed_rows[r].typed ? directed_rows[r].want
                                        : predict_downsample(directed_rows[r].blk));
    end
    wait_for_results();

    for (int n = 0; n < RANDOM_BLOCKS; n++) begin
      block_t blk;
      if (n % CHUNK_BLOCKS == 0) begin
        idle_on = ((n / CHUNK_BLOCKS) % 4) != 3;
      end
      if (n == RANDOM_BLOCKS / 2) begin
        wait_for_results();
      end
      blk = random_block();
      send_block(blk, predict_downsample(blk));
    end
    pix_in_bus.valid <= 1'b0;

    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      report_mismatch($sformatf("%0d expected beats never arrived", pending_pixels.size()));
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    int         gap;
    mip_pixel_t want;
    wait (rst == 1'b0);
    forever begin
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        pix_out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pix_out_bus.ready <= 1'b1;
      do @(posedge clk); while (!pix_out_bus.valid);
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected output beat %h %h %h %h",
                                  pix_out_bus.channel_zero, pix_out_bus.channel_one,
                                  pix_out_bus.channel_two, pix_out_bus.alpha_out));
      end else begin
        want = pending_pixels.pop_front();
        if (pix_out_bus.channel_zero !== want.ch0) begin
          report_mismatch($sformatf("channel_zero got %h want %h",
                                    pix_out_bus.channel_zero, want.ch0));
        end
        if (pix_out_bus.channel_one !== want.ch1) begin
          report_mismatch($sformatf("channel_one got %h want %h",
                                    pix_out_bus.channel_one, want.ch1));
        end
        if (pix_out_bus.channel_two !== want.ch2) begin
          report_mismatch($sformatf("channel_two got %h want %h",
                                    pix_out_bus.channel_two, want.ch2));
        end
        if (pix_out_bus.alpha_out !== want.alpha) begin
          report_mismatch($sformatf("alpha_out got %h want %h",
                                    pix_out_bus.alpha_out, want.alpha));
        end
      end
    end
  end

endmodule
